// ----- hw/rtl/lcdw_pkg.sv -----
// Shared types and constants for the character-LCD 4-bit write sequencer.
// Used by the front classifier, the job queue and the phase sequencer.
// No dependencies.
`default_nettype none

package lcdw_pkg;

    // Request codes on the input channel
    typedef enum logic [2:0] {
        CMD_INIT   = 3'd0,
        CMD_BYTE   = 3'd1,
        CMD_DATA   = 3'd2,
        CMD_CURSOR = 3'd3,
        CMD_CLEAR  = 3'd4,
        CMD_HOME   = 3'd5,
        CMD_GLYPH  = 3'd6
    } cmd_t;

    // Controller command bytes
    localparam logic [7:0] LCD_FUNC_SET   = 8'h28;
    localparam logic [7:0] LCD_DISP_ON    = 8'h0C;
    localparam logic [7:0] LCD_CLR_DISP   = 8'h01;
    localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] LCD_RET_HOME   = 8'h02;
    localparam logic [1:0] LCD_CGRAM_TOP  = 2'b01;
    localparam logic       LCD_DDRAM_TOP  = 1'b1;
    localparam logic [3:0] LCD_WAKE_NIB   = 4'h3;
    localparam logic [3:0] LCD_4BIT_NIB   = 4'h2;

    // Hold times in delay units
    localparam logic [15:0] T_STROBE     = 16'd3000;
    localparam logic [15:0] T_BYTE       = 16'd5000;
    localparam logic [15:0] T_POWER      = 16'd50000;
    localparam logic [15:0] T_INIT_SHORT = 16'd2000;
    localparam logic [15:0] W_BYTE_END   = 16'(T_STROBE + T_BYTE);
    localparam logic [15:0] W_LONG_END   = 16'(T_STROBE + T_BYTE + T_BYTE);
    localparam logic [15:0] W_SHORT_END  = 16'(T_STROBE + T_INIT_SHORT);

    // Phase counts
    localparam int INIT_PHASES = 25;
    localparam int BYTE_PHASES = 4;
    localparam int IDX_W       = $clog2(INIT_PHASES);

    // Job queue sizing
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified request
    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic [7:0] data;
        logic       long_tail;
    } job_t;

    // One pin phase
    typedef struct packed {
        logic        rs;
        logic        en;
        logic [3:0]  nibble;
        logic [15:0] wait_units;
        logic        last;
    } phase_t;

    // Sequencer states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } seq_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lcdw_front.sv -----
// Front end: takes requests and classifies them into byte or init jobs.
// Depends on lcdw_pkg.
`default_nettype none

module lcdw_front (
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [2:0]    s_command,
    input  wire logic [7:0]    s_value,
    input  wire logic [5:0]    s_column,
    input  wire logic          s_row,
    input  wire logic [2:0]    s_slot,
    input  wire logic          q_full,
    output logic               q_push,
    output lcdw_pkg::job_t     q_job
);

    logic known;

    // Accept while the queue has room
    assign s_ready = ~q_full;

    // Build the job for each request code; drop the unused code
    always_comb begin
        known           = 1'b1;
        q_job.is_init   = 1'b0;
        q_job.rs        = 1'b0;
        q_job.data      = s_value;
        q_job.long_tail = 1'b0;
        case (s_command)
            lcdw_pkg::CMD_INIT: begin
                q_job.is_init = 1'b1;
            end
            lcdw_pkg::CMD_BYTE: begin
                q_job.data = s_value;
            end
            lcdw_pkg::CMD_DATA: begin
                q_job.rs = 1'b1;
            end
            lcdw_pkg::CMD_CURSOR: begin
                // row base is 0x00 or 0x40 and column < 64, so the sum is a concat
                q_job.data = {lcdw_pkg::LCD_DDRAM_TOP, s_row, s_column};
            end
            lcdw_pkg::CMD_CLEAR: begin
                q_job.data      = lcdw_pkg::LCD_CLR_DISP;
                q_job.long_tail = 1'b1;
            end
            lcdw_pkg::CMD_HOME: begin
                q_job.data      = lcdw_pkg::LCD_RET_HOME;
                q_job.long_tail = 1'b1;
            end
            lcdw_pkg::CMD_GLYPH: begin
                q_job.data = {lcdw_pkg::LCD_CGRAM_TOP, s_slot, 3'b000};
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    assign q_push = s_valid & s_ready & known;

endmodule

`default_nettype wire

// ----- hw/rtl/lcdw_queue.sv -----
// Short job queue between the front end and the phase sequencer.
// Depends on lcdw_pkg.
`default_nettype none

module lcdw_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire lcdw_pkg::job_t  push_job,
    input  wire logic            pop,
    output lcdw_pkg::job_t       head_job,
    output logic                 head_valid,
    output logic                 full
);

    lcdw_pkg::job_t                 entry_reg [lcdw_pkg::QUEUE_DEPTH];
    logic [lcdw_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [lcdw_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [lcdw_pkg::QCNT_W-1:0]    count_reg, count_next;

    localparam logic [lcdw_pkg::QPTR_W-1:0] PTR_LAST =
        lcdw_pkg::QPTR_W'(lcdw_pkg::QUEUE_DEPTH - 1);
    localparam logic [lcdw_pkg::QCNT_W-1:0] CNT_FULL =
        lcdw_pkg::QCNT_W'(lcdw_pkg::QUEUE_DEPTH);

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CNT_FULL);
    assign head_job   = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold job payloads
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg < CNT_FULL || pop))
        else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("job queue underflow");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/lcdw_back.sv -----
// Back end: walks each queued job through its pin phases, one per cycle while
// the output slot is free, into an output register. Depends on lcdw_pkg.
`default_nettype none

module lcdw_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire lcdw_pkg::job_t  q_job,
    input  wire logic            q_valid,
    output logic                 q_pop,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic                 m_reg_select,
    output logic                 m_enable,
    output logic [3:0]           m_nibble,
    output logic [15:0]          m_wait_units,
    output logic                 m_last
);

    lcdw_pkg::seq_state_t           state_reg, state_next;
    lcdw_pkg::job_t                 job_reg, job_next;
    logic [lcdw_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic                           m_valid_reg, m_valid_next;
    lcdw_pkg::phase_t               out_reg;
    lcdw_pkg::phase_t               phase;
    logic                           out_free;
    logic                           load_out;

    // Build one phase from its fields
    function automatic lcdw_pkg::phase_t mk(input logic en, input logic [3:0] nib,
                                             input logic [15:0] w, input logic last);
        lcdw_pkg::phase_t p;
        p.rs         = 1'b0;
        p.en         = en;
        p.nibble     = nib;
        p.wait_units = w;
        p.last       = last;
        return p;
    endfunction

    // Power-up sequence, one entry per phase
    function automatic lcdw_pkg::phase_t init_phase(input logic [lcdw_pkg::IDX_W-1:0] idx);
        lcdw_pkg::phase_t p;
        p = '0;
        case (idx)
            5'd0:  p = mk(1'b0, 4'h0, lcdw_pkg::T_POWER, 1'b0);
            5'd1:  p = mk(1'b1, lcdw_pkg::LCD_WAKE_NIB, lcdw_pkg::T_STROBE, 1'b0);
            5'd2:  p = mk(1'b0, lcdw_pkg::LCD_WAKE_NIB, lcdw_pkg::W_BYTE_END, 1'b0);
            5'd3:  p = mk(1'b1, lcdw_pkg::LCD_WAKE_NIB, lcdw_pkg::T_STROBE, 1'b0);
            5'd4:  p = mk(1'b0, lcdw_pkg::LCD_WAKE_NIB, lcdw_pkg::W_SHORT_END, 1'b0);
            5'd5:  p = mk(1'b1, lcdw_pkg::LCD_WAKE_NIB, lcdw_pkg::T_STROBE, 1'b0);
            5'd6:  p = mk(1'b0, lcdw_pkg::LCD_WAKE_NIB, lcdw_pkg::W_SHORT_END, 1'b0);
            5'd7:  p = mk(1'b1, lcdw_pkg::LCD_4BIT_NIB, lcdw_pkg::T_STROBE, 1'b0);
            5'd8:  p = mk(1'b0, lcdw_pkg::LCD_4BIT_NIB, lcdw_pkg::W_SHORT_END, 1'b0);
            5'd9:  p = mk(1'b1, lcdw_pkg::LCD_FUNC_SET[7:4], lcdw_pkg::T_STROBE, 1'b0);
            5'd10: p = mk(1'b0, lcdw_pkg::LCD_FUNC_SET[7:4], lcdw_pkg::T_STROBE, 1'b0);
            5'd11: p = mk(1'b1, lcdw_pkg::LCD_FUNC_SET[3:0], lcdw_pkg::T_STROBE, 1'b0);
            5'd12: p = mk(1'b0, lcdw_pkg::LCD_FUNC_SET[3:0], lcdw_pkg::W_BYTE_END, 1'b0);
            5'd13: p = mk(1'b1, lcdw_pkg::LCD_DISP_ON[7:4], lcdw_pkg::T_STROBE, 1'b0);
            5'd14: p = mk(1'b0, lcdw_pkg::LCD_DISP_ON[7:4], lcdw_pkg::T_STROBE, 1'b0);
            5'd15: p = mk(1'b1, lcdw_pkg::LCD_DISP_ON[3:0], lcdw_pkg::T_STROBE, 1'b0);
            5'd16: p = mk(1'b0, lcdw_pkg::LCD_DISP_ON[3:0], lcdw_pkg::W_BYTE_END, 1'b0);
            5'd17: p = mk(1'b1, lcdw_pkg::LCD_CLR_DISP[7:4], lcdw_pkg::T_STROBE, 1'b0);
            5'd18: p = mk(1'b0, lcdw_pkg::LCD_CLR_DISP[7:4], lcdw_pkg::T_STROBE, 1'b0);
            5'd19: p = mk(1'b1, lcdw_pkg::LCD_CLR_DISP[3:0], lcdw_pkg::T_STROBE, 1'b0);
            5'd20: p = mk(1'b0, lcdw_pkg::LCD_CLR_DISP[3:0], lcdw_pkg::W_LONG_END, 1'b0);
            5'd21: p = mk(1'b1, lcdw_pkg::LCD_ENTRY_MODE[7:4], lcdw_pkg::T_STROBE, 1'b0);
            5'd22: p = mk(1'b0, lcdw_pkg::LCD_ENTRY_MODE[7:4], lcdw_pkg::T_STROBE, 1'b0);
            5'd23: p = mk(1'b1, lcdw_pkg::LCD_ENTRY_MODE[3:0], lcdw_pkg::T_STROBE, 1'b0);
            5'd24: p = mk(1'b0, lcdw_pkg::LCD_ENTRY_MODE[3:0], lcdw_pkg::W_BYTE_END, 1'b1);
            default: p = '0;
        endcase
        return p;
    endfunction

    // Select phase: init table, else high nibble strobe, release, low strobe, release
    always_comb begin
        if (job_reg.is_init) begin
            phase = init_phase(idx_reg);
        end else begin
            phase.rs     = job_reg.rs;
            phase.en     = ~idx_reg[0];
            phase.nibble = idx_reg[1] ? job_reg.data[3:0] : job_reg.data[7:4];
            phase.last   = (idx_reg == lcdw_pkg::IDX_W'(lcdw_pkg::BYTE_PHASES - 1));
            if (phase.last) begin
                phase.wait_units = job_reg.long_tail ? lcdw_pkg::W_LONG_END
                                                     : lcdw_pkg::W_BYTE_END;
            end else begin
                phase.wait_units = lcdw_pkg::T_STROBE;
            end
        end
    end

    assign out_free = ~m_valid_reg | m_ready;

    // Next state: emit a phase whenever the output slot frees, chain jobs without a gap
    always_comb begin
        state_next   = state_reg;
        job_next     = job_reg;
        idx_next     = idx_reg;
        q_pop        = 1'b0;
        load_out     = 1'b0;
        m_valid_next = m_valid_reg & ~m_ready;
        case (state_reg)
            lcdw_pkg::ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    job_next   = q_job;
                    idx_next   = '0;
                    state_next = lcdw_pkg::ST_RUN;
                end
            end
            lcdw_pkg::ST_RUN: begin
                if (out_free) begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    if (phase.last) begin
                        if (q_valid) begin
                            q_pop    = 1'b1;
                            job_next = q_job;
                            idx_next = '0;
                        end else begin
                            state_next = lcdw_pkg::ST_IDLE;
                        end
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = lcdw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lcdw_pkg::ST_IDLE;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold job and output payload
    always_ff @(posedge aclk) begin
        job_reg <= job_next;
        if (load_out) begin
            out_reg <= phase;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_reg_select = out_reg.rs;
    assign m_enable     = out_reg.en;
    assign m_nibble     = out_reg.nibble;
    assign m_wait_units = out_reg.wait_units;
    assign m_last       = out_reg.last;

`ifndef NO_ASSERTIONS
    a_byte_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lcdw_pkg::ST_RUN && !job_reg.is_init)
            |-> (idx_reg < lcdw_pkg::IDX_W'(lcdw_pkg::BYTE_PHASES)))
        else $error("byte phase index out of range");
    a_init_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lcdw_pkg::ST_RUN && job_reg.is_init)
            |-> (idx_reg < lcdw_pkg::IDX_W'(lcdw_pkg::INIT_PHASES)))
        else $error("init phase index out of range");
    a_strobe_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.en) |-> (out_reg.wait_units == lcdw_pkg::T_STROBE))
        else $error("enable-high phase with wrong hold time");
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && state_reg == lcdw_pkg::ST_RUN) |-> (phase.last && out_free))
        else $error("job taken before the current one finished");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/char_lcd_4bit_write_sequencer.sv -----
// Character-LCD 4-bit write sequencer, top level.
// Instantiates lcdw_front, lcdw_queue and lcdw_back; depends on lcdw_pkg.
//
// Input channel (s_*): one request per item: init, command byte, data byte,
// set cursor, clear, home or glyph slot. Code 7 is taken and ignored.
// Output channel (m_*): one pin phase per item (RS, EN, D4..D7 nibble and
// hold time in delay units); m_last marks the final phase of a request.
// A byte request yields 4 phases, init yields 25.
// A taken request passes through the queue entry, the job register and the
// output register before its first phase is valid. Throughput is one phase per
// cycle while the receiver is ready; consecutive requests follow with no gap
// when the next job is already queued, paced by the phase sequencer.
// A 4-entry job queue sits between the front end and the sequencer; s_ready
// drops only when it is full. When the receiver stalls, the output register
// holds its phase and the sequencer pauses; the front keeps taking requests
// until the queue fills.
// Reset (aresetn low, synchronous) empties the queue and idles the sequencer.
`default_nettype none

module char_lcd_4bit_write_sequencer (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [2:0]   s_command,
    input  wire logic [7:0]   s_value,
    input  wire logic [5:0]   s_column,
    input  wire logic         s_row,
    input  wire logic [2:0]   s_slot,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic              m_reg_select,
    output logic              m_enable,
    output logic [3:0]        m_nibble,
    output logic [15:0]       m_wait_units,
    output logic              m_last
);

    lcdw_pkg::job_t push_job;
    lcdw_pkg::job_t head_job;
    logic           push;
    logic           pop;
    logic           head_valid;
    logic           q_full;

    // Classify requests
    lcdw_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_value   (s_value),
        .s_column  (s_column),
        .s_row     (s_row),
        .s_slot    (s_slot),
        .q_full    (q_full),
        .q_push    (push),
        .q_job     (push_job)
    );

    // Buffer jobs
    lcdw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .head_job   (head_job),
        .head_valid (head_valid),
        .full       (q_full)
    );

    // Sequence pin phases
    lcdw_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_job        (head_job),
        .q_valid      (head_valid),
        .q_pop        (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_reg_select (m_reg_select),
        .m_enable     (m_enable),
        .m_nibble     (m_nibble),
        .m_wait_units (m_wait_units),
        .m_last       (m_last)
    );

endmodule

`default_nettype wire

// ----- tb/lcd_phase_checker.sv -----
`timescale 1ns / 1ps
// Checker for the character-LCD 4-bit write sequencer: predicts the pin phases of
// every request taken on the s_ channel and compares the m_ channel against them.
// Depends on lcdw_pkg for the request codes and the phase record.
module lcd_phase_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [2:0]  s_command,
    input  wire logic [7:0]  s_value,
    input  wire logic [5:0]  s_column,
    input  wire logic        s_row,
    input  wire logic [2:0]  s_slot,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic        m_reg_select,
    input  wire logic        m_enable,
    input  wire logic [3:0]  m_nibble,
    input  wire logic [15:0] m_wait_units,
    input  wire logic        m_last,
    output int               error_count,
    output int               expected_count,
    output int               phase_count
);

    // Controller timing in delay units
    localparam logic [15:0] HOLD_STROBE     = 16'd3000;
    localparam logic [15:0] HOLD_BYTE       = 16'd5000;
    localparam logic [15:0] HOLD_POWER      = 16'd50000;
    localparam logic [15:0] HOLD_WAKE_SHORT = 16'd2000;

    // Controller command bytes and nibbles
    localparam logic [7:0] SET_DDRAM     = 8'h80;
    localparam logic [7:0] ROW1_BASE     = 8'h40;
    localparam logic [7:0] SET_CGRAM     = 8'h40;
    localparam logic [7:0] FUNC_4BIT_2LN = 8'h28;
    localparam logic [7:0] DISPLAY_ON    = 8'h0C;
    localparam logic [7:0] CLEAR_DISPLAY = 8'h01;
    localparam logic [7:0] ENTRY_INC     = 8'h06;
    localparam logic [7:0] RETURN_HOME   = 8'h02;
    localparam logic [3:0] WAKE_NIB      = 4'h3;
    localparam logic [3:0] FOUR_BIT_NIB  = 4'h2;

    lcdw_pkg::phase_t phases_due[$];
    lcdw_pkg::phase_t req_phases[$];

    task automatic report_mismatch(input string what);
        $display("tb: mismatch at phase %0d: %s", phase_count, what);
        error_count++;
    endtask

    task automatic add_phase(input logic rs, input logic en, input logic [3:0] nib,
                             input logic [15:0] hold);
        lcdw_pkg::phase_t p;
        p.rs         = rs;
        p.en         = en;
        p.nibble     = nib;
        p.wait_units = hold;
        p.last       = 1'b0;
        req_phases.push_back(p);
    endtask

    // Lengthen the hold of the most recent phase
    task automatic stretch_tail(input logic [15:0] extra);
        lcdw_pkg::phase_t p;
        if (req_phases.size() > 0) begin
            p = req_phases.pop_back();
            p.wait_units = p.wait_units + extra;
            req_phases.push_back(p);
        end
    endtask

    task automatic add_nibble(input logic rs, input logic [3:0] nib);
        add_phase(rs, 1'b1, nib, HOLD_STROBE);
        add_phase(rs, 1'b0, nib, HOLD_STROBE);
    endtask

    task automatic add_byte(input logic rs, input logic [7:0] b);
        add_nibble(rs, b[7:4]);
        add_nibble(rs, b[3:0]);
        stretch_tail(HOLD_BYTE);
    endtask

    // Expand one request into its pin phases and queue them
    task automatic predict_request(input logic [2:0] cmd, input logic [7:0] val,
                                   input logic [5:0] col, input logic rw,
                                   input logic [2:0] sl);
        logic [7:0]       addr;
        lcdw_pkg::phase_t p;
        req_phases.delete();
        case (cmd)
            lcdw_pkg::CMD_INIT: begin
                add_phase(1'b0, 1'b0, 4'h0, HOLD_POWER);
                add_nibble(1'b0, WAKE_NIB);
                stretch_tail(HOLD_BYTE);
                add_nibble(1'b0, WAKE_NIB);
                stretch_tail(HOLD_WAKE_SHORT);
                add_nibble(1'b0, WAKE_NIB);
                stretch_tail(HOLD_WAKE_SHORT);
                add_nibble(1'b0, FOUR_BIT_NIB);
                stretch_tail(HOLD_WAKE_SHORT);
                add_byte(1'b0, FUNC_4BIT_2LN);
                add_byte(1'b0, DISPLAY_ON);
                add_byte(1'b0, CLEAR_DISPLAY);
                stretch_tail(HOLD_BYTE);
                add_byte(1'b0, ENTRY_INC);
            end
            lcdw_pkg::CMD_BYTE: add_byte(1'b0, val);
            lcdw_pkg::CMD_DATA: add_byte(1'b1, val);
            lcdw_pkg::CMD_CURSOR: begin
                addr = (rw ? ROW1_BASE : 8'h00) + {2'b00, col};
                add_byte(1'b0, SET_DDRAM | {1'b0, addr[6:0]});
            end
            lcdw_pkg::CMD_CLEAR: begin
                add_byte(1'b0, CLEAR_DISPLAY);
                stretch_tail(HOLD_BYTE);
            end
            lcdw_pkg::CMD_HOME: begin
                add_byte(1'b0, RETURN_HOME);
                stretch_tail(HOLD_BYTE);
            end
            lcdw_pkg::CMD_GLYPH: add_byte(1'b0, SET_CGRAM | {2'b00, sl, 3'b000});
            default: ;
        endcase
        if (req_phases.size() > 0) begin
            p = req_phases.pop_back();
            p.last = 1'b1;
            req_phases.push_back(p);
        end
        while (req_phases.size() > 0) begin
            phases_due.push_back(req_phases.pop_front());
        end
    endtask

    // Compare each phase taken, then expand each request taken
    always @(posedge aclk) begin
        lcdw_pkg::phase_t want;
        if (!aresetn) begin
            phases_due.delete();
            error_count = 0;
            phase_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (phases_due.size() == 0) begin
                    report_mismatch("phase with no request pending");
                end else begin
                    want = phases_due.pop_front();
                    if (m_reg_select !== want.rs)
                        report_mismatch($sformatf("reg_select got %b want %b",
                                                  m_reg_select, want.rs));
                    if (m_enable !== want.en)
                        report_mismatch($sformatf("enable got %b want %b",
                                                  m_enable, want.en));
                    if (m_nibble !== want.nibble)
                        report_mismatch($sformatf("nibble got %h want %h",
                                                  m_nibble, want.nibble));
                    if (m_wait_units !== want.wait_units)
                        report_mismatch($sformatf("wait_units got %0d want %0d",
                                                  m_wait_units, want.wait_units));
                    if (m_last !== want.last)
                        report_mismatch($sformatf("last got %b want %b",
                                                  m_last, want.last));
                end
                phase_count++;
            end
            if (s_valid && s_ready) begin
                predict_request(s_command, s_value, s_column, s_row, s_slot);
            end
        end
        expected_count = phases_due.size();
    end

endmodule

// ----- tb/char_lcd_4bit_write_sequencer_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the character-LCD 4-bit write sequencer: clock, reset and
// request stimulus with random idling; checking is done by lcd_phase_checker.
// Depends on lcdw_pkg, the sequencer RTL and lcd_phase_checker.
module char_lcd_4bit_write_sequencer_tb;

    localparam logic [2:0] CMD_UNUSED   = 3'd7;
    localparam int         RANDOM_ITEMS = 330;
    localparam int         CALM_FROM    = 290;
    localparam int         HOLD_AT      = 120;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         DRAIN_CYCLES = 40;
    localparam int         CYCLE_LIMIT  = 300000;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_command;
    logic [7:0]  s_value;
    logic [5:0]  s_column;
    logic        s_row;
    logic [2:0]  s_slot;
    logic        m_valid;
    logic        m_ready;
    logic        m_reg_select;
    logic        m_enable;
    logic [3:0]  m_nibble;
    logic [15:0] m_wait_units;
    logic        m_last;

    int error_count;
    int expected_count;
    int phase_count;
    int cycle_count = 0;
    int sent_total  = 0;
    int sent_init   = 0;
    int sent_unused = 0;
    bit idle_on     = 1'b1;
    bit hold_off_req = 1'b0;
    bit hold_done    = 1'b0;

    char_lcd_4bit_write_sequencer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_command(s_command), .s_value(s_value), .s_column(s_column),
        .s_row(s_row), .s_slot(s_slot),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_reg_select(m_reg_select), .m_enable(m_enable), .m_nibble(m_nibble),
        .m_wait_units(m_wait_units), .m_last(m_last)
    );

    lcd_phase_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_command(s_command), .s_value(s_value), .s_column(s_column),
        .s_row(s_row), .s_slot(s_slot),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_reg_select(m_reg_select), .m_enable(m_enable), .m_nibble(m_nibble),
        .m_wait_units(m_wait_units), .m_last(m_last),
        .error_count(error_count), .expected_count(expected_count),
        .phase_count(phase_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        forever begin
            if (hold_off_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    // Offer one request and hold it until taken
    task automatic send_request(input logic [2:0] cmd, input logic [7:0] val,
                                input logic [5:0] col, input logic rw,
                                input logic [2:0] sl);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_value   <= val;
        s_column  <= col;
        s_row     <= rw;
        s_slot    <= sl;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_total++;
        if (cmd == lcdw_pkg::CMD_INIT) sent_init++;
        if (cmd == CMD_UNUSED) sent_unused++;
    endtask

    function automatic logic [2:0] pick_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)       return lcdw_pkg::CMD_INIT;
        else if (r < 24) return lcdw_pkg::CMD_BYTE;
        else if (r < 50) return lcdw_pkg::CMD_DATA;
        else if (r < 66) return lcdw_pkg::CMD_CURSOR;
        else if (r < 72) return lcdw_pkg::CMD_CLEAR;
        else if (r < 78) return lcdw_pkg::CMD_HOME;
        else if (r < 92) return lcdw_pkg::CMD_GLYPH;
        else             return CMD_UNUSED;
    endfunction

    initial begin
        int         counted;
        logic [2:0] cmd;
        counted = 0;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_command <= lcdw_pkg::CMD_INIT;
        s_value   <= 8'h00;
        s_column  <= 6'd0;
        s_row     <= 1'b0;
        s_slot    <= 3'd0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: every request kind and the field extremes
        send_request(lcdw_pkg::CMD_INIT,   8'h00, 6'd0,  1'b0, 3'd0);
        send_request(lcdw_pkg::CMD_BYTE,   8'h00, 6'd63, 1'b1, 3'd7);
        send_request(lcdw_pkg::CMD_BYTE,   8'hFF, 6'd0,  1'b0, 3'd0);
        send_request(lcdw_pkg::CMD_BYTE,   8'hA5, 6'd21, 1'b1, 3'd5);
        send_request(lcdw_pkg::CMD_DATA,   8'h00, 6'd0,  1'b0, 3'd0);
        send_request(lcdw_pkg::CMD_DATA,   8'hFF, 6'd63, 1'b1, 3'd7);
        send_request(lcdw_pkg::CMD_DATA,   8'h5A, 6'd42, 1'b0, 3'd2);
        send_request(lcdw_pkg::CMD_CURSOR, 8'hFF, 6'd0,  1'b0, 3'd7);
        send_request(lcdw_pkg::CMD_CURSOR, 8'h00, 6'd63, 1'b1, 3'd0);
        send_request(lcdw_pkg::CMD_CURSOR, 8'h3C, 6'd63, 1'b0, 3'd3);
        send_request(lcdw_pkg::CMD_CURSOR, 8'hC3, 6'd0,  1'b1, 3'd4);
        send_request(lcdw_pkg::CMD_CLEAR,  8'hFF, 6'd63, 1'b1, 3'd7);
        send_request(lcdw_pkg::CMD_HOME,   8'h00, 6'd0,  1'b0, 3'd0);
        send_request(lcdw_pkg::CMD_GLYPH,  8'h00, 6'd0,  1'b0, 3'd0);
        send_request(lcdw_pkg::CMD_GLYPH,  8'hFF, 6'd63, 1'b1, 3'd7);
        send_request(lcdw_pkg::CMD_GLYPH,  8'h96, 6'd9,  1'b0, 3'd5);
        send_request(CMD_UNUSED,           8'hFF, 6'd63, 1'b1, 3'd7);
        send_request(CMD_UNUSED,           8'h00, 6'd0,  1'b0, 3'd0);
        send_request(lcdw_pkg::CMD_DATA,   8'h81, 6'd17, 1'b1, 3'd1);
        send_request(lcdw_pkg::CMD_INIT,   8'hFF, 6'd63, 1'b1, 3'd7);

        // Random requests; ignored code 7 does not count toward RANDOM_ITEMS
        while (counted < RANDOM_ITEMS) begin
            if (counted == HOLD_AT) hold_off_req = 1'b1;
            if (counted >= CALM_FROM) idle_on = 1'b0;
            cmd = pick_command();
            send_request(cmd, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                         1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
            if (cmd != CMD_UNUSED) counted++;
        end
        s_valid <= 1'b0;

        // Drain every expected phase, then let the pipeline settle
        @(posedge aclk);
        while (expected_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("tb: %0d requests taken (%0d init, %0d ignored code), %0d phases checked",
                 sent_total, sent_init, sent_unused, phase_count);
        $display("tb: included a %0d-cycle receiver hold-off with requests queued",
                 HOLD_CYCLES);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: %0d mismatches", error_count);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
